// ===== hw/rtl/ptw_pkg.sv =====
`default_nettype none

package ptw_pkg;

   // Fixed geometry of the 10/10/12 split
   localparam int DIR_ENTRIES   = 1024;
   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W         = 10;
   localparam int OFF_W         = 12;
   localparam int FRAME_W       = 20;
   localparam int ADDR_W        = 32;
   localparam int ENTRY_W       = 32;
   localparam int DIR_LSB       = 22;
   localparam int TBL_LSB       = 12;

   // Defaults for the top level parameters
   localparam int TABLE_SLOTS_DEF     = 16;
   localparam int IDENTITY_TABLES_DEF = 4;

   // Entry flag bits
   localparam logic [OFF_W-1:0] FLAG_PRESENT = 12'h001;
   localparam logic [OFF_W-1:0] IDENT_FLAGS  = 12'h003;

   // Request modes
   localparam logic [1:0] MODE_MAP       = 2'd0;
   localparam logic [1:0] MODE_UNMAP     = 2'd1;
   localparam logic [1:0] MODE_TRANSLATE = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_NOT_MAPPED = 2'd1;
   localparam logic [1:0] STATUS_NO_SLOT    = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIR,
      ST_TBL,
      ST_CLEAR,
      ST_HOLD
   } ctrl_state_type;

   // Finished result handed from the walker to the output register
   typedef struct packed {
      logic              valid;
      logic [1:0]        status;
      logic [ADDR_W-1:0] phys_out;
   } res_beat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ptw_ifs.sv =====
`default_nettype none

// Request channel
interface ptw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] virt_addr;
   logic [31:0] phys_addr;
   logic [11:0] page_flags;

   modport source (output valid, output mode, output virt_addr, output phys_addr,
                   output page_flags, input ready);
   modport sink   (input valid, input mode, input virt_addr, input phys_addr,
                   input page_flags, output ready);
endinterface

// Response channel
interface ptw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] phys_out;

   modport source (output valid, output status, output phys_out, input ready);
   modport sink   (input valid, input status, input phys_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/two_level_page_table_walker.sv =====
// Sequence: a request beat is accepted in ST_IDLE and its directory entry is read in ST_DIR;
// there map and unmap write the table entry, translate adds a table read in ST_TBL, and a
// map that allocates a table clears the whole new slot in ST_CLEAR. The result then waits in
// ST_HOLD, and a new request is taken only as it leaves; both memories have single ports.
// Reset: synchronous; afterwards a sweep writes the directory and the identity tables,
// with req_bus.ready low throughout.
`default_nettype none

module two_level_page_table_walker #(
   parameter int TABLE_SLOTS     = ptw_pkg::TABLE_SLOTS_DEF,
   parameter int IDENTITY_TABLES = ptw_pkg::IDENTITY_TABLES_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   ptw_req_if.sink   req_bus,
   ptw_rsp_if.source rsp_bus
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int TA_W   = SLOT_W + ptw_pkg::IDX_W;

   ptw_pkg::res_beat_type        res_beat;
   logic                         res_ready;
   logic                         dir_we;
   logic [ptw_pkg::IDX_W-1:0]    dir_addr;
   logic [SLOT_W:0]              dir_wdata;
   logic [SLOT_W:0]              dir_rdata;
   logic                         tbl_we;
   logic [TA_W-1:0]              tbl_addr;
   logic [ptw_pkg::ENTRY_W-1:0]  tbl_wdata;
   logic [ptw_pkg::ENTRY_W-1:0]  tbl_rdata;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_status_ff;
   logic [ptw_pkg::ADDR_W-1:0]   rsp_phys_ff;

   ptw_ctrl #(
      .TABLE_SLOTS     (TABLE_SLOTS),
      .IDENTITY_TABLES (IDENTITY_TABLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .res_ready (res_ready),
      .res_beat  (res_beat),
      .dir_we    (dir_we),
      .dir_addr  (dir_addr),
      .dir_wdata (dir_wdata),
      .dir_rdata (dir_rdata),
      .tbl_we    (tbl_we),
      .tbl_addr  (tbl_addr),
      .tbl_wdata (tbl_wdata),
      .tbl_rdata (tbl_rdata)
   );

   // Directory: present bit and slot per entry
   ptw_ram #(
      .DEPTH (ptw_pkg::DIR_ENTRIES),
      .WIDTH (SLOT_W + 1)
   ) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .addr  (dir_addr),
      .wdata (dir_wdata),
      .rdata (dir_rdata)
   );

   // Table pool: TABLE_SLOTS tables of 1024 entries
   ptw_ram #(
      .DEPTH (TABLE_SLOTS * ptw_pkg::TABLE_ENTRIES),
      .WIDTH (ptw_pkg::ENTRY_W)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .addr  (tbl_addr),
      .wdata (tbl_wdata),
      .rdata (tbl_rdata)
   );

   // Output register: takes a new beat whenever empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) rsp_valid_in = res_beat.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_beat.valid) begin
         rsp_status_ff <= res_beat.status;
         rsp_phys_ff   <= res_beat.phys_out;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.phys_out = rsp_phys_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ptw_ram.sv =====
`default_nettype none

module ptw_ram #(
   parameter int DEPTH = ptw_pkg::DIR_ENTRIES,
   parameter int WIDTH = ptw_pkg::ENTRY_W
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ptw_ctrl.sv =====
`default_nettype none

module ptw_ctrl #(
   parameter int TABLE_SLOTS     = ptw_pkg::TABLE_SLOTS_DEF,
   parameter int IDENTITY_TABLES = ptw_pkg::IDENTITY_TABLES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   ptw_req_if.sink                      req_bus,
   input  wire logic                    res_ready,
   output ptw_pkg::res_beat_type        res_beat,
   // directory memory port
   output logic                         dir_we,
   output logic [ptw_pkg::IDX_W-1:0]    dir_addr,
   output logic [$clog2(TABLE_SLOTS):0] dir_wdata,
   input  wire logic [$clog2(TABLE_SLOTS):0] dir_rdata,
   // table memory port
   output logic                         tbl_we,
   output logic [$clog2(TABLE_SLOTS)+ptw_pkg::IDX_W-1:0] tbl_addr,
   output logic [ptw_pkg::ENTRY_W-1:0]  tbl_wdata,
   input  wire logic [ptw_pkg::ENTRY_W-1:0] tbl_rdata
);

   localparam int SLOT_W    = $clog2(TABLE_SLOTS);
   localparam int NSLOT_W   = $clog2(TABLE_SLOTS + 1);
   localparam int IDENT_LEN = IDENTITY_TABLES * ptw_pkg::TABLE_ENTRIES;
   localparam int INIT_LEN  = (IDENT_LEN > ptw_pkg::DIR_ENTRIES) ? IDENT_LEN
                                                                 : ptw_pkg::DIR_ENTRIES;
   localparam int CNT_W     = $clog2(INIT_LEN);
   localparam int IDX_W     = ptw_pkg::IDX_W;

   ptw_pkg::ctrl_state_type state_ff, state_in;

   logic [CNT_W-1:0]              sweep_cnt_ff, sweep_cnt_in;
   logic [NSLOT_W-1:0]            next_slot_ff, next_slot_in;
   logic [1:0]                    mode_ff;
   logic [IDX_W-1:0]              didx_ff;
   logic [IDX_W-1:0]              tidx_ff;
   logic [ptw_pkg::OFF_W-1:0]     offset_ff;
   logic [ptw_pkg::ENTRY_W-1:0]   new_ent_ff;
   logic [1:0]                    res_status_ff, res_status_in;
   logic [ptw_pkg::ADDR_W-1:0]    res_phys_ff, res_phys_in;

   logic                          req_fire;
   logic                          dir_present;
   logic [SLOT_W-1:0]             dir_slot;
   logic                          pool_empty;
   logic                          init_last;
   logic                          clear_last;
   logic                          in_ident;
   logic                          in_dir;

   assign req_fire    = req_bus.valid && req_bus.ready;
   assign dir_present = dir_rdata[SLOT_W];
   assign dir_slot    = dir_rdata[SLOT_W-1:0];
   assign pool_empty  = (next_slot_ff >= NSLOT_W'(TABLE_SLOTS));
   assign init_last   = (sweep_cnt_ff == CNT_W'(INIT_LEN - 1));
   assign clear_last  = (sweep_cnt_ff[IDX_W-1:0] == {IDX_W{1'b1}});
   assign in_ident    = ({1'b0, sweep_cnt_ff} < (CNT_W+1)'(IDENT_LEN));
   assign in_dir      = ({1'b0, sweep_cnt_ff} < (CNT_W+1)'(ptw_pkg::DIR_ENTRIES));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptw_pkg::ST_INIT: begin
            if (init_last) state_in = ptw_pkg::ST_IDLE;
         end
         ptw_pkg::ST_IDLE: begin
            if (req_fire) state_in = ptw_pkg::ST_DIR;
         end
         ptw_pkg::ST_DIR: begin
            case (mode_ff)
               ptw_pkg::MODE_MAP: begin
                  if (!dir_present && !pool_empty) state_in = ptw_pkg::ST_CLEAR;
                  else                             state_in = ptw_pkg::ST_HOLD;
               end
               ptw_pkg::MODE_TRANSLATE: begin
                  if (dir_present) state_in = ptw_pkg::ST_TBL;
                  else             state_in = ptw_pkg::ST_HOLD;
               end
               default: state_in = ptw_pkg::ST_HOLD;
            endcase
         end
         ptw_pkg::ST_TBL: state_in = ptw_pkg::ST_HOLD;
         ptw_pkg::ST_CLEAR: begin
            if (clear_last) state_in = ptw_pkg::ST_HOLD;
         end
         ptw_pkg::ST_HOLD: begin
            if (res_ready) begin
               if (req_fire) state_in = ptw_pkg::ST_DIR;
               else          state_in = ptw_pkg::ST_IDLE;
            end
         end
         default: state_in = ptw_pkg::ST_INIT;
      endcase
   end

   // Outputs: memory accesses, handshake and result
   always_comb begin
      req_bus.ready = 1'b0;
      dir_we        = 1'b0;
      dir_addr      = req_bus.virt_addr[ptw_pkg::DIR_LSB +: IDX_W];
      dir_wdata     = '0;
      tbl_we        = 1'b0;
      tbl_addr      = {dir_slot, tidx_ff};
      tbl_wdata     = '0;
      res_status_in = res_status_ff;
      res_phys_in   = res_phys_ff;
      next_slot_in  = next_slot_ff;
      sweep_cnt_in  = '0;
      case (state_ff)
         // reset sweep: directory rows and identity tables
         ptw_pkg::ST_INIT: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            dir_we       = in_dir;
            dir_addr     = sweep_cnt_ff[IDX_W-1:0];
            dir_wdata    = {({1'b0, sweep_cnt_ff} < (CNT_W+1)'(IDENTITY_TABLES)),
                            sweep_cnt_ff[SLOT_W-1:0]};
            tbl_we       = in_ident;
            tbl_addr     = (SLOT_W+IDX_W)'(sweep_cnt_ff);
            tbl_wdata    = {ptw_pkg::FRAME_W'(sweep_cnt_ff), ptw_pkg::IDENT_FLAGS};
         end
         ptw_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         // directory entry is on the read port
         ptw_pkg::ST_DIR: begin
            res_status_in = ptw_pkg::STATUS_DONE;
            res_phys_in   = '0;
            case (mode_ff)
               ptw_pkg::MODE_MAP: begin
                  if (dir_present) begin
                     tbl_we    = 1'b1;
                     tbl_wdata = new_ent_ff;
                  end else if (pool_empty) begin
                     res_status_in = ptw_pkg::STATUS_NO_SLOT;
                  end
               end
               ptw_pkg::MODE_UNMAP: begin
                  if (dir_present) tbl_we = 1'b1;
                  else             res_status_in = ptw_pkg::STATUS_NOT_MAPPED;
               end
               ptw_pkg::MODE_TRANSLATE: begin
                  if (!dir_present) res_status_in = ptw_pkg::STATUS_NOT_MAPPED;
               end
               default: res_status_in = ptw_pkg::STATUS_DONE;
            endcase
         end
         // table entry is on the read port
         ptw_pkg::ST_TBL: begin
            if (tbl_rdata[0]) begin
               res_status_in = ptw_pkg::STATUS_DONE;
               res_phys_in   = {tbl_rdata[ptw_pkg::ENTRY_W-1:ptw_pkg::OFF_W], offset_ff};
            end else begin
               res_status_in = ptw_pkg::STATUS_NOT_MAPPED;
               res_phys_in   = '0;
            end
         end
         // clear the new slot; the mapped entry goes in on its own row
         ptw_pkg::ST_CLEAR: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            tbl_we       = 1'b1;
            tbl_addr     = {next_slot_ff[SLOT_W-1:0], sweep_cnt_ff[IDX_W-1:0]};
            tbl_wdata    = (sweep_cnt_ff[IDX_W-1:0] == tidx_ff) ? new_ent_ff : '0;
            dir_addr     = didx_ff;
            if (clear_last) begin
               dir_we       = 1'b1;
               dir_wdata    = {1'b1, next_slot_ff[SLOT_W-1:0]};
               next_slot_in = next_slot_ff + 1'b1;
            end
         end
         ptw_pkg::ST_HOLD: begin
            req_bus.ready = res_ready;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   assign res_beat.valid    = (state_ff == ptw_pkg::ST_HOLD);
   assign res_beat.status   = res_status_ff;
   assign res_beat.phys_out = res_phys_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptw_pkg::ST_INIT;
         sweep_cnt_ff <= '0;
         next_slot_ff <= NSLOT_W'(IDENTITY_TABLES);
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         next_slot_ff <= next_slot_in;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= req_bus.mode;
         didx_ff    <= req_bus.virt_addr[ptw_pkg::DIR_LSB +: IDX_W];
         tidx_ff    <= req_bus.virt_addr[ptw_pkg::TBL_LSB +: IDX_W];
         offset_ff  <= req_bus.virt_addr[ptw_pkg::OFF_W-1:0];
         new_ent_ff <= {req_bus.phys_addr[ptw_pkg::ADDR_W-1:ptw_pkg::OFF_W],
                        req_bus.page_flags | ptw_pkg::FLAG_PRESENT};
      end
      res_status_ff <= res_status_in;
      res_phys_ff   <= res_phys_in;
   end

endmodule

`default_nettype wire

// ===== sim/tb_two_level_page_table_walker.sv =====
`default_nettype none

// One result beat as the walker should produce it
typedef struct {
   logic [1:0]  status;
   logic [31:0] phys_out;
} walk_result_type;

// Shadow page tables plus the queue of results still owed by the walker
class page_walk_board;
   localparam int SLOTS  = ptw_pkg::TABLE_SLOTS_DEF;
   localparam int IDENTS = ptw_pkg::IDENTITY_TABLES_DEF;
   localparam int TBL_N  = ptw_pkg::TABLE_ENTRIES;

   bit              dir_live [ptw_pkg::DIR_ENTRIES];
   int unsigned     dir_slot [ptw_pkg::DIR_ENTRIES];
   logic [31:0]     entries  [SLOTS*TBL_N];
   int unsigned     next_free;
   walk_result_type owed [$];
   int              errors;

   function new();
      logic [31:0] page;
      for (int d = 0; d < ptw_pkg::DIR_ENTRIES; d++) begin
         dir_live[d] = 1'b0;
         dir_slot[d] = 0;
      end
      // first IDENTS directories map 4 MB each onto themselves
      for (int s = 0; s < IDENTS; s++) begin
         for (int j = 0; j < TBL_N; j++) begin
            page = s * TBL_N + j;
            entries[s*TBL_N + j] = (page << ptw_pkg::TBL_LSB) | ptw_pkg::IDENT_FLAGS;
         end
         dir_live[s] = 1'b1;
         dir_slot[s] = s;
      end
      next_free = IDENTS;
      errors    = 0;
   endfunction

   // Walk the shadow tables for one accepted request beat
   function void note_request(logic [1:0] mode, logic [31:0] va, logic [31:0] pa,
                              logic [11:0] fl);
      int unsigned     d;
      int unsigned     t;
      logic [31:0]     ent;
      walk_result_type res;
      d = 32'(va[ptw_pkg::DIR_LSB +: ptw_pkg::IDX_W]);
      t = 32'(va[ptw_pkg::TBL_LSB +: ptw_pkg::IDX_W]);
      res.status   = ptw_pkg::STATUS_DONE;
      res.phys_out = '0;
      case (mode)
         ptw_pkg::MODE_MAP: begin
            if (!dir_live[d]) begin
               if (next_free >= SLOTS) begin
                  res.status = ptw_pkg::STATUS_NO_SLOT;
               end else begin
                  for (int j = 0; j < TBL_N; j++) entries[next_free*TBL_N + j] = '0;
                  dir_slot[d] = next_free;
                  dir_live[d] = 1'b1;
                  next_free++;
               end
            end
            if (res.status == ptw_pkg::STATUS_DONE)
               entries[dir_slot[d]*TBL_N + t] = {pa[31:12], fl | ptw_pkg::FLAG_PRESENT};
         end
         ptw_pkg::MODE_UNMAP: begin
            if (!dir_live[d]) res.status = ptw_pkg::STATUS_NOT_MAPPED;
            else entries[dir_slot[d]*TBL_N + t] = '0;
         end
         ptw_pkg::MODE_TRANSLATE: begin
            ent = '0;
            if (dir_live[d]) ent = entries[dir_slot[d]*TBL_N + t];
            if ((ent[11:0] & ptw_pkg::FLAG_PRESENT) == '0)
               res.status = ptw_pkg::STATUS_NOT_MAPPED;
            else
               res.phys_out = {ent[31:12], va[11:0]};
         end
         default: ;  // spare mode: no effect
      endcase
      owed.push_back(res);
   endfunction

   // Compare one response beat against the oldest owed result
   function void check_result(logic [1:0] st, logic [31:0] po, time stamp);
      walk_result_type want;
      if (owed.size() == 0) begin
         $display("%0t ns: unexpected beat, status %0d phys_out %h", stamp, st, po);
         errors++;
         return;
      end
      want = owed.pop_front();
      if (st !== want.status) begin
         $display("%0t ns: status expected %0d actual %0d", stamp, want.status, st);
         errors++;
      end
      if (po !== want.phys_out) begin
         $display("%0t ns: phys_out expected %h actual %h", stamp, want.phys_out, po);
         errors++;
      end
   endfunction

   function int pending();
      return owed.size();
   endfunction
endclass

module tb_two_level_page_table_walker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int         RANDOM_ITEMS = 1580;
   localparam int         CALM_FROM    = 1400;
   localparam int         SQUEEZE_AT   = 300;
   localparam int         SQUEEZE_LEN  = 250;
   localparam int         STALL_LIMIT  = 20000;

   logic clock;
   logic reset;

   ptw_req_if req_ch ();
   ptw_rsp_if rsp_ch ();

   two_level_page_table_walker #(
      .TABLE_SLOTS     (ptw_pkg::TABLE_SLOTS_DEF),
      .IDENTITY_TABLES (ptw_pkg::IDENTITY_TABLES_DEF)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   page_walk_board board;
   bit             calm;
   bit             squeeze_rsp;
   int             quiet_cycles;
   int unsigned    known_dirs [$];

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Known levels from time zero
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.mode      = ptw_pkg::MODE_TRANSLATE;
      req_ch.virt_addr = '0;
      req_ch.phys_addr = '0;
      req_ch.page_flags = '0;
      rsp_ch.ready     = 1'b0;
      calm             = 1'b0;
      squeeze_rsp      = 1'b0;
      quiet_cycles     = 0;
      board            = new();
   end

   // Beat monitor: results first, then new requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_result(rsp_ch.status, rsp_ch.phys_out, $time);
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            board.note_request(req_ch.mode, req_ch.virt_addr, req_ch.phys_addr,
                               req_ch.page_flags);
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Response side: random stall bursts, one long hold-off, none when calm
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (squeeze_rsp) begin
            squeeze_rsp = 1'b0;
            rsp_ch.ready <= 1'b0;
            n = SQUEEZE_LEN;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 14);
         end else begin
            rsp_ch.ready <= 1'b1;
            n = $urandom_range(1, 60);
         end
         repeat (n) @(negedge clock);
      end
   end

   // Offer one request beat; entered and left at a falling edge
   task automatic send_req(input logic [1:0] mode, input logic [31:0] va,
                           input logic [31:0] pa, input logic [11:0] fl);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= mode;
      req_ch.virt_addr  <= va;
      req_ch.phys_addr  <= pa;
      req_ch.page_flags <= fl;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // One random request, mostly aimed at directories already in use
   task automatic send_random();
      int unsigned pick;
      logic [9:0]  d;
      logic [9:0]  t;
      logic [1:0]  mode;
      logic [31:0] va;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         // map into a random directory: allocation or pool exhausted
         va   = $urandom;
         mode = ptw_pkg::MODE_MAP;
         known_dirs.push_back(32'(va[31:22]));
      end else if (pick < 7) begin
         va   = $urandom;
         mode = (pick == 6) ? MODE_SPARE : 2'($urandom_range(0, 2));
      end else begin
         d = 10'(known_dirs[$urandom_range(0, known_dirs.size() - 1)]);
         t = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 15)) : 10'($urandom);
         va = {d, t, 12'($urandom)};
         pick = $urandom_range(0, 99);
         if (pick < 35)      mode = ptw_pkg::MODE_MAP;
         else if (pick < 55) mode = ptw_pkg::MODE_UNMAP;
         else                mode = ptw_pkg::MODE_TRANSLATE;
      end
      send_req(mode, va, $urandom, 12'($urandom));
   endtask

   // Main sequence
   initial begin
      known_dirs = '{0, 1, 2, 3};
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // identity window edges and an absent directory
      send_req(ptw_pkg::MODE_TRANSLATE, 32'h0000_0000, '0, '0);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'h00FF_FFFF, '0, '0);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, '0, '0);
      // present bit forced on even when the flags leave it clear
      send_req(ptw_pkg::MODE_MAP, 32'h0040_0123, 32'hFFFF_FFFF, 12'hFFE);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'h0040_0ABC, '0, '0);
      // new directory takes a fresh slot, the rest of that table reads empty
      send_req(ptw_pkg::MODE_MAP, 32'hFFFF_F000, 32'h0000_0000, 12'h000);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, '0, '0);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'hFFC0_0000, '0, '0);
      known_dirs.push_back(32'(10'h3FF));
      // unmap with no table behind the directory entry
      send_req(ptw_pkg::MODE_UNMAP, 32'h8000_0000, '0, '0);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'h8000_0000, '0, '0);
      // unmap, then unmap again an entry already cleared
      send_req(ptw_pkg::MODE_UNMAP, 32'h0040_0000, '0, '0);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'h0040_0FFF, '0, '0);
      send_req(ptw_pkg::MODE_UNMAP, 32'h0040_0000, '0, '0);
      // spare mode does nothing
      send_req(MODE_SPARE, 32'h0000_1000, 32'hFFFF_FFFF, 12'hFFF);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'h0000_1234, '0, '0);
      // remap an identity page with every flag bit
      send_req(ptw_pkg::MODE_MAP, 32'h0000_1000, 32'h1234_5678, 12'hFFF);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'h0000_1FFF, '0, '0);
      send_req(ptw_pkg::MODE_UNMAP, 32'h00FF_F000, '0, '0);
      send_req(ptw_pkg::MODE_TRANSLATE, 32'h00FF_F000, '0, '0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == SQUEEZE_AT) squeeze_rsp = 1'b1;
         if (i == CALM_FROM)  calm = 1'b1;
         send_random();
      end
      req_ch.valid <= 1'b0;

      // drain, then a few cycles for anything stray
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
